// ===== rtl/cht_pkg.sv =====
// shared types, constants and the key mix function for the chained hash table
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_ENTRIES = 1024;

    // shift amounts of the key mix
    localparam int SH_A = 21;
    localparam int SH_B = 24;
    localparam int SH_C = 3;
    localparam int SH_D = 8;
    localparam int SH_E = 14;
    localparam int SH_F = 2;
    localparam int SH_G = 4;
    localparam int SH_H = 28;
    localparam int SH_I = 31;

    localparam logic [1:0] HASH_LAST_STEP = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } cht_op_t;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } cht_status_t;

    typedef struct packed {
        logic        load;
        logic        hash_en;
        logic        head_rd;
        logic        ent_rd_head;
        logic        ent_miss;
        logic        val_upd;
        logic        alloc_wr;
        logic        link_wr;
        logic        sweep_wr;
        logic        free_clr;
        logic        rsp_en;
        cht_status_t rsp_status;
        logic        rsp_val;
    } cht_cmd_t;

    typedef struct packed {
        logic hash_last;
        logic head_valid;
        logic key_hit;
        logic link_ok;
        logic pool_full;
        logic sweep_done;
    } cht_stat_t;

    // one of four mix rounds, each one wide add chain, plus an xor in all but the first
    function automatic logic [63:0] cht_hash_step(input logic [63:0] h,
                                                  input logic [1:0]  step);
        logic [63:0] g;
        logic [63:0] r;
        begin
            g = '0;
            r = '0;
            unique case (step)
                2'd0:
                begin
                    r = (~h) + (h << SH_A);
                end
                2'd1:
                begin
                    g = h ^ (h >> SH_B);
                    r = g + (g << SH_C) + (g << SH_D);
                end
                2'd2:
                begin
                    g = h ^ (h >> SH_E);
                    r = g + (g << SH_F) + (g << SH_G);
                end
                2'd3:
                begin
                    g = h ^ (h >> SH_H);
                    r = g + (g << SH_I);
                end
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cht_dpath.sv =====
// datapath: key mix, bucket head memory, entry pool memories and result registers
`timescale 1ns / 1ps
`default_nettype none

module cht_dpath
    import cht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] key,
    input  wire logic [31:0] value,
    input  wire cht_cmd_t    cmd,
    output cht_stat_t        stat,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      value_out
);

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(ENTRIES);
    localparam int NW = IW + 1;
    localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);
    localparam logic [NW-1:0] NFULL = NW'(ENTRIES);

    logic [IW:0]   heads [BUCKETS];
    logic [63:0]   ekeys [ENTRIES];
    logic [31:0]   evals [ENTRIES];
    logic [IW:0]   elinks[ENTRIES];

    logic [63:0]   key_reg, hash_reg;
    logic [31:0]   value_reg;
    logic [1:0]    hstep_reg;
    logic [IW:0]   head_q;
    logic [63:0]   key_q;
    logic [31:0]   val_q;
    logic [IW:0]   link_q;
    logic [IW-1:0] cur_reg, last_reg;
    logic          has_last_reg;
    logic [NW-1:0] nf_reg;
    logic [BW-1:0] sweep_cnt_reg;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [31:0]   value_out_reg;

    logic [BW-1:0] bucket;
    logic [IW-1:0] nf_idx;
    logic [IW-1:0] ent_ra;
    logic          ent_re;
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [IW:0]   head_wd;
    logic          val_we;
    logic [IW-1:0] val_wa;
    logic          link_we;
    logic [IW-1:0] link_wa;
    logic [IW:0]   link_wd;

    assign bucket  = hash_reg[BW-1:0] & BMASK;
    assign nf_idx  = nf_reg[IW-1:0];
    assign ent_re  = cmd.ent_rd_head | cmd.ent_miss;
    assign ent_ra  = cmd.ent_rd_head ? head_q[IW-1:0] : link_q[IW-1:0];

    assign head_we = cmd.sweep_wr | (cmd.link_wr & ~has_last_reg);
    assign head_wa = cmd.sweep_wr ? sweep_cnt_reg : bucket;
    assign head_wd = cmd.sweep_wr ? '0 : {1'b1, nf_idx};

    assign val_we  = cmd.alloc_wr | cmd.val_upd;
    assign val_wa  = cmd.alloc_wr ? nf_idx : cur_reg;

    assign link_we = cmd.alloc_wr | (cmd.link_wr & has_last_reg);
    assign link_wa = cmd.alloc_wr ? nf_idx : last_reg;
    assign link_wd = cmd.alloc_wr ? '0 : {1'b1, nf_idx};

    assign stat.hash_last  = (hstep_reg == HASH_LAST_STEP);
    assign stat.head_valid = head_q[IW];
    assign stat.key_hit    = (key_q == key_reg);
    assign stat.link_ok    = link_q[IW];
    assign stat.pool_full  = (nf_reg == NFULL);
    assign stat.sweep_done = (sweep_cnt_reg == BMASK);

    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            heads[head_wa] <= head_wd;
        end
        if (cmd.head_rd)
        begin
            head_q <= heads[bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_wr)
        begin
            ekeys[nf_idx] <= key_reg;
        end
        if (ent_re)
        begin
            key_q <= ekeys[ent_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            evals[val_wa] <= value_reg;
        end
        if (ent_re)
        begin
            val_q <= evals[ent_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            elinks[link_wa] <= link_wd;
        end
        if (ent_re)
        begin
            link_q <= elinks[ent_ra];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= key;
            value_reg <= value;
        end
        if (cmd.load)
        begin
            hash_reg <= key;
        end
        else if (cmd.hash_en)
        begin
            hash_reg <= cht_hash_step(hash_reg, hstep_reg);
        end
        if (ent_re)
        begin
            cur_reg <= ent_ra;
        end
        if (cmd.ent_miss)
        begin
            last_reg <= cur_reg;
        end
        if (cmd.rsp_en)
        begin
            status_reg    <= cmd.rsp_status;
            value_out_reg <= cmd.rsp_val ? val_q : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstep_reg     <= '0;
            has_last_reg  <= 1'b0;
            nf_reg        <= '0;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.rsp_en;
            if (cmd.load)
            begin
                hstep_reg <= '0;
            end
            else if (cmd.hash_en)
            begin
                hstep_reg <= hstep_reg + 2'd1;
            end
            if (cmd.load)
            begin
                has_last_reg <= 1'b0;
            end
            else if (cmd.ent_miss)
            begin
                has_last_reg <= 1'b1;
            end
            if (cmd.free_clr)
            begin
                nf_reg <= '0;
            end
            else if (cmd.link_wr)
            begin
                nf_reg <= nf_reg + NW'(1);
            end
            if (cmd.sweep_wr)
            begin
                sweep_cnt_reg <= stat.sweep_done ? '0 : sweep_cnt_reg + BW'(1);
            end
        end
    end

    a_no_alloc_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_wr |-> !stat.pool_full)
        else $error("entry allocated from a full pool");

    a_link_bumps_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_wr |=> nf_reg == $past(nf_reg) + NW'(1))
        else $error("free count not advanced after append");

    a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_wr && stat.sweep_done) |=> sweep_cnt_reg == '0)
        else $error("sweep counter not back at zero");

    a_rsp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_en |=> done_reg)
        else $error("response not strobed");

endmodule

`default_nettype wire

// ===== rtl/cht_ctrl.sv =====
// controller: sequences hashing, chain walk, append and head-memory sweep
`timescale 1ns / 1ps
`default_nettype none

module cht_ctrl
    import cht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic [1:0] opcode,
    input  wire cht_stat_t stat,
    output logic           busy,
    output cht_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_HEAD  = 8'b0000_1000,
        S_HCHK  = 8'b0001_0000,
        S_ECHK  = 8'b0010_0000,
        S_ALLOC = 8'b0100_0000,
        S_LINK  = 8'b1000_0000
    } cht_state_t;

    cht_state_t state_reg, state_next;
    cht_op_t    op_reg, op_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = cht_op_t'(opcode);
                    unique case (cht_op_t'(opcode))
                        OP_CLEAR:
                        begin
                            cmd.rsp_en     = 1'b1;
                            cmd.rsp_status = ST_HIT;
                            cmd.free_clr   = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        OP_NONE:
                        begin
                            cmd.rsp_en     = 1'b1;
                            cmd.rsp_status = ST_HIT;
                        end
                        OP_INSERT, OP_FIND:
                        begin
                            state_next = S_HASH;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                cmd.hash_en = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HCHK;
            end
            S_HCHK, S_ECHK:
            begin
                if (state_reg == S_HCHK && stat.head_valid)
                begin
                    cmd.ent_rd_head = 1'b1;
                    state_next      = S_ECHK;
                end
                else if (state_reg == S_ECHK && stat.key_hit)
                begin
                    cmd.val_upd    = (op_reg == OP_INSERT);
                    cmd.rsp_en     = 1'b1;
                    cmd.rsp_status = ST_HIT;
                    cmd.rsp_val    = (op_reg == OP_FIND);
                    state_next     = S_IDLE;
                end
                else if (state_reg == S_ECHK && stat.link_ok)
                begin
                    cmd.ent_miss = 1'b1;
                end
                else
                begin
                    // end of chain reached without a match
                    cmd.ent_miss = (state_reg == S_ECHK);
                    if (op_reg == OP_FIND)
                    begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_MISS;
                        state_next     = S_IDLE;
                    end
                    else if (stat.pool_full)
                    begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.alloc_wr = 1'b1;
                state_next   = S_LINK;
            end
            S_LINK:
            begin
                cmd.link_wr    = 1'b1;
                cmd.rsp_en     = 1'b1;
                cmd.rsp_status = ST_MISS;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table.sv =====
// top level of the chained hash table: controller plus datapath
`timescale 1ns / 1ps
`default_nettype none

// Key-value table of 64-bit keys and 32-bit values, chained buckets over a
// fixed entry pool. Pulse start with opcode/key/value while busy is low; one
// result beat follows on done, one cycle wide, and it cannot be held off.
// A find or insert runs key mixing, a head memory read, then one entry
// memory read per link of the chain; an empty bucket answers without an
// entry read, and an append to the chain adds an allocate and a link step.
// Clear answers at once, then keeps busy high while the head memory is
// swept to empty; the same sweep runs after reset.
// Unused opcode 3 answers status 0 without touching the table.

module chained_hash_table
    import cht_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] key,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      value_out
);

    cht_cmd_t  cmd;
    cht_stat_t stat;

    // sequencing of each beat
    cht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    // mixing, memories and result registers
    cht_dpath #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .status    (status),
        .value_out (value_out)
    );

endmodule

`default_nettype wire
